@@ hw/rtl/segment_intersection_macros.svh @@
// Assertion macros for the segment intersection block
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH
`ifndef SYNTHESIS
`define SI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("segment_intersection assertion failed");
`define SI_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("segment_intersection forbidden condition");
`else
`define SI_ASSERT(label, clk, rst, prop)
`define SI_NEVER(label, clk, rst, cond)
`endif
`endif

@@ hw/rtl/segint_pkg.sv @@
// Types and constants shared by the segment intersection block
package segint_pkg;
   localparam int CW = 16;
   localparam int DFW = CW + 1;
   localparam int PW = 2 * DFW;
   localparam int DW = PW + 1;
   localparam int UW = DW - 1;
   localparam int MW = DFW;
   localparam int QW = DFW;
   localparam int NW = MW + UW;
   localparam int QDEPTH = 4;
   localparam int QAW = 2;
   localparam int QCW = 3;

   typedef enum logic [1:0] {
      ST_HIT = 2'd0,
      ST_PARALLEL = 2'd1,
      ST_MISS = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [CW-1:0] ax;
      logic signed [CW-1:0] ay;
      logic signed [CW-1:0] bx;
      logic signed [CW-1:0] by_coord;
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
   } req_type;

   typedef struct packed {
      status_type status;
      logic signed [CW-1:0] ix;
      logic signed [CW-1:0] iy;
   } rsp_type;

   typedef struct packed {
      status_type status;
      logic signed [CW-1:0] ax;
      logic signed [CW-1:0] ay;
      logic ma_neg;
      logic mc_neg;
      logic [MW-1:0] ma_mag;
      logic [MW-1:0] mc_mag;
      logic [UW-1:0] tn;
      logic [UW-1:0] det;
   } job_type;
endpackage

@@ hw/rtl/segint_front.sv @@
// Front end: differences, cross products, determinant and classification
`include "segment_intersection_macros.svh"
module segint_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  segint_pkg::req_type req,
   output logic job_valid,
   output segint_pkg::job_type job,
   output logic [1:0] in_flight
);
   import segint_pkg::*;

   logic v1_ff, v2_ff, v3_ff;
   logic signed [DFW-1:0] ma_ff, mb_ff, mc_ff, md_ff, r1_ff, r2_ff;
   logic signed [CW-1:0] ax1_ff, ay1_ff, ax2_ff, ay2_ff;
   logic signed [DFW-1:0] ma2_ff, mc2_ff;
   logic signed [PW-1:0] pad_ff, pbc_ff, pdr_ff, pbr_ff, par_ff, pcr_ff;
   job_type job_ff, job_in;
   logic signed [DW-1:0] det, tn, sn, dn, tnn, snn;
   logic signed [DFW-1:0] ma_abs, mc_abs;
   logic neg;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff <= DFW'(req.bx) - DFW'(req.ax);
      mb_ff <= DFW'(req.cx) - DFW'(req.dx);
      mc_ff <= DFW'(req.by_coord) - DFW'(req.ay);
      md_ff <= DFW'(req.cy) - DFW'(req.dy);
      r1_ff <= DFW'(req.cx) - DFW'(req.ax);
      r2_ff <= DFW'(req.cy) - DFW'(req.ay);
      ax1_ff <= req.ax;
      ay1_ff <= req.ay;
      pad_ff <= PW'(ma_ff) * PW'(md_ff);
      pbc_ff <= PW'(mb_ff) * PW'(mc_ff);
      pdr_ff <= PW'(md_ff) * PW'(r1_ff);
      pbr_ff <= PW'(mb_ff) * PW'(r2_ff);
      par_ff <= PW'(ma_ff) * PW'(r2_ff);
      pcr_ff <= PW'(mc_ff) * PW'(r1_ff);
      ma2_ff <= ma_ff;
      mc2_ff <= mc_ff;
      ax2_ff <= ax1_ff;
      ay2_ff <= ay1_ff;
      job_ff <= job_in;
   end

   always_comb begin
      det = DW'(pad_ff) - DW'(pbc_ff);
      tn = DW'(pdr_ff) - DW'(pbr_ff);
      sn = DW'(par_ff) - DW'(pcr_ff);
      neg = det[DW-1];
      dn = neg ? -det : det;
      tnn = neg ? -tn : tn;
      snn = neg ? -sn : sn;
      ma_abs = ma2_ff[DFW-1] ? -ma2_ff : ma2_ff;
      mc_abs = mc2_ff[DFW-1] ? -mc2_ff : mc2_ff;
      job_in.ax = ax2_ff;
      job_in.ay = ay2_ff;
      job_in.ma_neg = ma2_ff[DFW-1];
      job_in.mc_neg = mc2_ff[DFW-1];
      job_in.ma_mag = ma_abs[MW-1:0];
      job_in.mc_mag = mc_abs[MW-1:0];
      job_in.tn = tnn[UW-1:0];
      job_in.det = dn[UW-1:0];
      priority if (det == '0) begin
         job_in.status = ST_PARALLEL;
      end else if (tnn < 0 || tnn > dn || snn < 0 || snn > dn) begin
         job_in.status = ST_MISS;
      end else begin
         job_in.status = ST_HIT;
      end
   end

   assign job_valid = v3_ff;
   assign job = job_ff;
   assign in_flight = 2'(v1_ff) + 2'(v2_ff) + 2'(v3_ff);

   `SI_ASSERT(a_par_zero_det, clock, reset, v3_ff && job_ff.status == ST_PARALLEL |-> job_ff.det == '0)
   `SI_ASSERT(a_hit_in_range, clock, reset, v3_ff && job_ff.status == ST_HIT |-> job_ff.tn <= job_ff.det && job_ff.det != '0)
   `SI_ASSERT(a_pipe_flow, clock, reset, v1_ff |=> v2_ff)
endmodule

@@ hw/rtl/segint_queue.sv @@
// Short queue between front end and back end
`include "segment_intersection_macros.svh"
module segint_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  segint_pkg::job_type push_data,
   input  logic pop,
   output logic not_empty,
   output segint_pkg::job_type head,
   output logic [segint_pkg::QCW-1:0] count
);
   import segint_pkg::*;

   job_type mem_ff [0:QDEPTH-1];
   logic [QAW-1:0] wr_ff, rd_ff;
   logic [QCW-1:0] count_ff;
   logic do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         count_ff <= count_ff + QCW'(push) - QCW'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign not_empty = count_ff != '0;
   assign head = mem_ff[rd_ff];
   assign count = count_ff;

   `SI_NEVER(a_no_overflow, clock, reset, push && !do_pop && count_ff == QCW'(QDEPTH))
   `SI_NEVER(a_count_range, clock, reset, count_ff > QCW'(QDEPTH))
endmodule

@@ hw/rtl/segint_back.sv @@
// Back end: scale products and pipelined restoring division
`include "segment_intersection_macros.svh"
module segint_back (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   input  segint_pkg::job_type job,
   output logic rsp_valid,
   output segint_pkg::rsp_type rsp
);
   import segint_pkg::*;

   logic v_ff [0:QW];
   status_type st_ff [0:QW];
   logic signed [CW-1:0] ax_ff [0:QW];
   logic signed [CW-1:0] ay_ff [0:QW];
   logic nx_ff [0:QW];
   logic ny_ff [0:QW];
   logic [UW-1:0] det_ff [0:QW];
   logic [UW-1:0] rx_ff [0:QW];
   logic [UW-1:0] ry_ff [0:QW];
   logic [QW-1:0] lx_ff [0:QW];
   logic [QW-1:0] ly_ff [0:QW];
   logic [NW-1:0] px, py;
   logic done_ff;
   rsp_type rsp_ff, rsp_in;
   logic signed [DFW:0] sx, sy;

   assign px = NW'(job.ma_mag) * NW'(job.tn);
   assign py = NW'(job.mc_mag) * NW'(job.tn);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= job_valid;
      end
   end

   always_ff @(posedge clock) begin
      st_ff[0] <= job.status;
      ax_ff[0] <= job.ax;
      ay_ff[0] <= job.ay;
      nx_ff[0] <= job.ma_neg;
      ny_ff[0] <= job.mc_neg;
      det_ff[0] <= job.det;
      rx_ff[0] <= px[NW-1:QW];
      ry_ff[0] <= py[NW-1:QW];
      lx_ff[0] <= px[QW-1:0];
      ly_ff[0] <= py[QW-1:0];
   end

   for (genvar k = 1; k <= QW; k++) begin : g_div
      logic [UW:0] tx, ty;
      logic gx, gy;
      assign tx = {rx_ff[k-1], lx_ff[k-1][QW-1]};
      assign ty = {ry_ff[k-1], ly_ff[k-1][QW-1]};
      assign gx = tx >= {1'b0, det_ff[k-1]};
      assign gy = ty >= {1'b0, det_ff[k-1]};
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         st_ff[k] <= st_ff[k-1];
         ax_ff[k] <= ax_ff[k-1];
         ay_ff[k] <= ay_ff[k-1];
         nx_ff[k] <= nx_ff[k-1];
         ny_ff[k] <= ny_ff[k-1];
         det_ff[k] <= det_ff[k-1];
         rx_ff[k] <= gx ? UW'(tx - {1'b0, det_ff[k-1]}) : tx[UW-1:0];
         ry_ff[k] <= gy ? UW'(ty - {1'b0, det_ff[k-1]}) : ty[UW-1:0];
         lx_ff[k] <= {lx_ff[k-1][QW-2:0], gx};
         ly_ff[k] <= {ly_ff[k-1][QW-2:0], gy};
      end
   end

   always_comb begin
      sx = (DFW+1)'(ax_ff[QW]) + (nx_ff[QW] ? -(DFW+1)'(lx_ff[QW]) : (DFW+1)'(lx_ff[QW]));
      sy = (DFW+1)'(ay_ff[QW]) + (ny_ff[QW] ? -(DFW+1)'(ly_ff[QW]) : (DFW+1)'(ly_ff[QW]));
      rsp_in.status = st_ff[QW];
      rsp_in.ix = '0;
      rsp_in.iy = '0;
      if (st_ff[QW] == ST_HIT) begin
         rsp_in.ix = sx[CW-1:0];
         rsp_in.iy = sy[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= v_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = done_ff;
   assign rsp = rsp_ff;

   `SI_ASSERT(a_miss_zero, clock, reset, done_ff && rsp_ff.status != ST_HIT |-> rsp_ff.ix == '0 && rsp_ff.iy == '0)
   `SI_ASSERT(a_out_follows, clock, reset, v_ff[QW] |=> done_ff)
endmodule

@@ hw/rtl/segment_intersection.sv @@
// Top level of the segment intersection block
// Segment intersection by Cramer's rule, signed Q8.8 coordinates.
// Request channel: drive req_data and raise start; the request is taken at a
// rising edge where start is high and busy is low.
// Result channel: rsp_valid is high for exactly one cycle with rsp_data
// holding status (hit, parallel, miss) and the point ix, iy (zero unless hit).
// The path from request to result runs through 23 register stages, counting
// the one loaded at the accepting edge: three front stages (differences,
// products, classify), one queue slot, one scaling multiply stage, 17
// restoring division stages, one output register.
// Throughput: one request per cycle; the division is fully pipelined, one
// quotient bit per stage, and the back end never stalls.
// busy rises only when the front stages and the queue, less the request that
// leaves it this cycle, hold as many requests as the queue has slots; the
// back end pops every cycle, so this never happens in operation.
// Reset (synchronous, active high) empties the pipeline and the queue;
// requests in flight are dropped and no result appears for them.
// The receiver cannot stall: every result is shown for one cycle only.
`include "segment_intersection_macros.svh"
module segment_intersection (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  segint_pkg::req_type req_data,
   output logic rsp_valid,
   output segint_pkg::rsp_type rsp_data
);
   import segint_pkg::*;

   logic accept;
   logic job_valid, q_not_empty;
   job_type job, head;
   logic [1:0] in_flight;
   logic [QCW-1:0] q_count;
   logic [QCW:0] used;

   assign used = (QCW+1)'(q_count) - (QCW+1)'(q_not_empty) + (QCW+1)'(in_flight);
   assign busy = used >= (QCW+1)'(QDEPTH);
   assign accept = start && !busy;

   segint_front u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(accept),
      .req(req_data),
      .job_valid(job_valid),
      .job(job),
      .in_flight(in_flight)
   );

   segint_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(job_valid),
      .push_data(job),
      .pop(q_not_empty),
      .not_empty(q_not_empty),
      .head(head),
      .count(q_count)
   );

   segint_back u_back (
      .clock(clock),
      .reset(reset),
      .job_valid(q_not_empty),
      .job(head),
      .rsp_valid(rsp_valid),
      .rsp(rsp_data)
   );

   `SI_NEVER(a_no_full_push, clock, reset, job_valid && q_count == QCW'(QDEPTH))
   `SI_ASSERT(a_busy_credit, clock, reset, !busy |-> used < (QCW+1)'(QDEPTH))
   `SI_ASSERT(a_accept_enters, clock, reset, accept |=> in_flight != 2'd0)
endmodule
